/* rtl/core/bfa_pkg.sv */
// ----------------------------------------------------------------------------
// bfa_pkg: shared types and constants of the best-fit allocator
// Table sizes, status and request codes, cell token and write-port types.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int MAX_BLOCKS = 16;
  localparam int NHOLES     = MAX_BLOCKS + 1;
  localparam int AW         = 32;
  localparam int UIW        = $clog2(MAX_BLOCKS);
  localparam int HIW        = $clog2(NHOLES);
  localparam int CW         = 5;

  localparam logic [AW-1:0] TOTAL_RESET = AW'(65536);

  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_FREE    = 2'd1;
  localparam logic [1:0] REQ_QUERY   = 2'd2;
  localparam logic [1:0] REQ_COMPACT = 2'd3;

  localparam logic [3:0] ST_ALLOCATED = 4'd0;
  localparam logic [3:0] ST_DUP       = 4'd1;
  localparam logic [3:0] ST_NO_SPACE  = 4'd2;
  localparam logic [3:0] ST_FREED     = 4'd3;
  localparam logic [3:0] ST_NOT_FOUND = 4'd4;
  localparam logic [3:0] ST_FOUND     = 4'd5;
  localparam logic [3:0] ST_QMISS     = 4'd6;
  localparam logic [3:0] ST_COMPACTED = 4'd7;
  localparam logic [3:0] ST_MOVED     = 4'd8;
  localparam logic [3:0] ST_FULL      = 4'd9;

  // token walking the block-table chain
  typedef struct packed {
    logic           go;
    logic [31:0]    key;
    logic           found;
    logic [UIW-1:0] fidx;
    logic [AW-1:0]  fstart;
    logic [AW-1:0]  fsize;
    logic           has_slot;
    logic [UIW-1:0] sidx;
    logic           sel;
    logic [UIW-1:0] sel_idx;
    logic [AW-1:0]  sel_start;
    logic [AW-1:0]  sel_size;
    logic [31:0]    sel_tag;
  } used_tok_t;

  // token walking the free-extent chain
  typedef struct packed {
    logic           go;
    logic [AW-1:0]  req;
    logic [AW-1:0]  s;
    logic [AW:0]    e;
    logic           fit;
    logic [HIW-1:0] fit_idx;
    logic [AW-1:0]  fit_start;
    logic [AW-1:0]  fit_size;
    logic           prev;
    logic [HIW-1:0] prev_idx;
    logic [AW-1:0]  prev_start;
    logic [AW-1:0]  prev_size;
    logic           nxt;
    logic [HIW-1:0] nxt_idx;
    logic [AW-1:0]  nxt_size;
    logic           slot;
    logic [HIW-1:0] slot_idx;
  } hole_tok_t;

  typedef struct packed {
    logic          valid;
    logic [31:0]   tag;
    logic [AW-1:0] start;
    logic [AW-1:0] size;
  } used_wr_t;

  typedef struct packed {
    logic          valid;
    logic [AW-1:0] start;
    logic [AW-1:0] size;
  } hole_wr_t;

  typedef struct packed {
    logic [3:0]    status;
    logic [31:0]   tag_out;
    logic [31:0]   block_start;
    logic [31:0]   block_size;
    logic [31:0]   new_start;
    logic [CW-1:0] move_count;
    logic          last;
  } rsp_word_t;

endpackage

/* rtl/core/bfa_if.sv */
// ----------------------------------------------------------------------------
// bfa_req_if / bfa_rsp_if: valid/ready channels of the allocator
// One word moves at a clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface bfa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] block_tag;
  logic [31:0] req_size;
  modport source (output valid, req_type, block_tag, req_size, input ready);
  modport sink   (input valid, req_type, block_tag, req_size, output ready);
endinterface

interface bfa_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [31:0] tag_out;
  logic [31:0] block_start;
  logic [31:0] block_size;
  logic [31:0] new_start;
  logic [4:0]  move_count;
  logic        last;
  modport source (output valid, status, tag_out, block_start, block_size, new_start,
                  move_count, last, input ready);
  modport sink   (input valid, status, tag_out, block_start, block_size, new_start,
                  move_count, last, output ready);
endinterface

/* rtl/core/bfa_used_cell.sv */
// ----------------------------------------------------------------------------
// bfa_used_cell: one entry of the block table
// Holds one block and updates the passing token: tag match, free slot,
// lowest-start block not yet packed.
// ----------------------------------------------------------------------------
module bfa_used_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [bfa_pkg::UIW-1:0] cell_idx,
  input  logic                    clr,
  input  logic                    wr_en,
  input  bfa_pkg::used_wr_t       wr,
  input  logic                    done_clr,
  input  logic                    done_set,
  input  bfa_pkg::used_tok_t      tok_in,
  output bfa_pkg::used_tok_t      tok_out
);

  logic                      valid;
  logic                      done;
  logic [31:0]               tag;
  logic [bfa_pkg::AW-1:0]    start;
  logic [bfa_pkg::AW-1:0]    size;
  bfa_pkg::used_tok_t        t;

  always_comb begin
    t = tok_in;
    if (valid && !t.found && tag == t.key) begin
      t.found  = 1'b1;
      t.fidx   = cell_idx;
      t.fstart = start;
      t.fsize  = size;
    end
    if (!valid && !t.has_slot) begin
      t.has_slot = 1'b1;
      t.sidx     = cell_idx;
    end
    // strict compare keeps the lower index on equal starts
    if (valid && !done && (!t.sel || start < t.sel_start)) begin
      t.sel       = 1'b1;
      t.sel_idx   = cell_idx;
      t.sel_start = start;
      t.sel_size  = size;
      t.sel_tag   = tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= 1'b0;
      done       <= 1'b0;
      tok_out.go <= 1'b0;
    end else begin
      tok_out <= t;
      if (wr_en) begin
        valid <= wr.valid;
      end else if (clr) begin
        valid <= 1'b0;
      end
      if (done_set) begin
        done <= 1'b1;
      end else if (done_clr) begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag   <= wr.tag;
      start <= wr.start;
      size  <= wr.size;
    end
  end

endmodule

/* rtl/core/bfa_hole_cell.sv */
// ----------------------------------------------------------------------------
// bfa_hole_cell: one entry of the free-extent table
// Holds one extent and updates the passing token: best fit, neighbors of a
// returned extent, first empty entry.
// ----------------------------------------------------------------------------
module bfa_hole_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [bfa_pkg::HIW-1:0] cell_idx,
  input  logic                    boot_valid,
  input  logic [bfa_pkg::AW-1:0]  boot_size,
  input  logic                    clr,
  input  logic                    wr_en,
  input  bfa_pkg::hole_wr_t       wr,
  input  bfa_pkg::hole_tok_t      tok_in,
  output bfa_pkg::hole_tok_t      tok_out
);

  logic                   valid;
  logic [bfa_pkg::AW-1:0] start;
  logic [bfa_pkg::AW-1:0] size;
  logic [bfa_pkg::AW:0]   hend;
  bfa_pkg::hole_tok_t     t;

  assign hend = {1'b0, start} + {1'b0, size};

  always_comb begin
    t = tok_in;
    if (valid && size >= t.req &&
        (!t.fit || size < t.fit_size || (size == t.fit_size && start < t.fit_start))) begin
      t.fit       = 1'b1;
      t.fit_idx   = cell_idx;
      t.fit_start = start;
      t.fit_size  = size;
    end
    if (valid && hend == {1'b0, t.s}) begin
      t.prev       = 1'b1;
      t.prev_idx   = cell_idx;
      t.prev_start = start;
      t.prev_size  = size;
    end
    if (valid && {1'b0, start} == t.e) begin
      t.nxt      = 1'b1;
      t.nxt_idx  = cell_idx;
      t.nxt_size = size;
    end
    if (!valid && !t.slot) begin
      t.slot     = 1'b1;
      t.slot_idx = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= boot_valid;
      start      <= '0;
      size       <= boot_size;
      tok_out.go <= 1'b0;
    end else begin
      tok_out <= t;
      if (wr_en) begin
        valid <= wr.valid;
        start <= wr.start;
        size  <= wr.size;
      end else if (clr) begin
        valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/best_fit_allocator_core.sv */
// ----------------------------------------------------------------------------
// best_fit_allocator_core: best-fit allocator with coalescing and compaction
// Block table and free-extent table are rows of cells; a token walks each
// row one cell per cycle and collects what the request needs.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake        word
//  -------  ---  ---------------  -----------------------------------------
//  req      in   valid / ready    req_type, block_tag, req_size
//  rsp      out  valid / ready    status, tag_out, block_start, block_size,
//                                 new_start, move_count, last
//  cfg      in   cfg_we           cfg_wdata = total_memory
//
//  A query walks the 16-cell block row once; alloc and free walk it and,
//  when needed, the 17-cell extent row, with arming and update steps.
//  Compact: one packing round per block plus one, each a walk of the block
//  row; a count pass, then a move pass only when the count found moves.
//  Reset (synchronous, rst high) and a cfg write empty the block table and
//  leave one free extent [0, total_memory) if not 0; the write applies at once.
//  A stalled rsp holds its word; the next request is taken while it waits.
//
module best_fit_allocator_core (
  input  logic                   clk,
  input  logic                   rst,
  bfa_req_if.sink                req,
  bfa_rsp_if.source              rsp,
  input  logic                   cfg_we,
  input  logic [31:0]            cfg_wdata
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_UPASS = 8'b0000_0010,
    S_HPASS = 8'b0000_0100,
    S_UPD2  = 8'b0000_1000,
    S_EMIT  = 8'b0001_0000,
    S_CEMIT = 8'b0010_0000,
    S_CMOVE = 8'b0100_0000,
    S_SPARE = 8'b1000_0000
  } state_t;

  state_t state;

  // request context
  logic [1:0]                  type_r;
  logic [31:0]                 tag_r;
  logic [bfa_pkg::AW-1:0]      size_r;
  logic [bfa_pkg::AW-1:0]      s_r;
  logic [bfa_pkg::AW:0]        e_r;
  logic [bfa_pkg::UIW-1:0]     slot_r;
  logic [bfa_pkg::HIW-1:0]     nxt_r;
  logic [bfa_pkg::AW-1:0]      total;

  // compaction
  logic                        phase;
  logic [bfa_pkg::AW:0]        cur;
  logic [bfa_pkg::CW-1:0]      moves;
  logic [bfa_pkg::CW-1:0]      k;
  logic [bfa_pkg::UIW-1:0]     mv_idx;
  logic [31:0]                 mv_tag;
  logic [bfa_pkg::AW-1:0]      mv_start;
  logic [bfa_pkg::AW-1:0]      mv_size;

  // cell control, all registered
  logic                        u_arm, u_go, h_arm, h_go;
  logic                        u_clr, h_clr;
  logic                        u_wr_go, h_wr_go;
  logic [bfa_pkg::UIW-1:0]     u_wr_idx;
  logic [bfa_pkg::HIW-1:0]     h_wr_idx;
  bfa_pkg::used_wr_t           u_wr;
  bfa_pkg::hole_wr_t           h_wr;
  logic                        done_clr, done_go;
  logic [bfa_pkg::UIW-1:0]     done_idx;

  bfa_pkg::rsp_word_t          res;
  bfa_pkg::rsp_word_t          out_w;
  logic                        out_v;

  bfa_pkg::used_tok_t          utok [bfa_pkg::MAX_BLOCKS+1];
  bfa_pkg::hole_tok_t          htok [bfa_pkg::NHOLES+1];
  bfa_pkg::used_tok_t          u_head;
  bfa_pkg::hole_tok_t          h_head;
  bfa_pkg::used_tok_t          ur;
  bfa_pkg::hole_tok_t          hr;

  logic                        out_free;
  logic                        moved;
  logic [bfa_pkg::AW:0]        cur_add;

  // tokens enter the rows in the cycle after the arm pulse, so a write issued
  // with the arm has landed before the first cell looks
  always_comb begin
    u_head     = '0;
    u_head.go  = u_go;
    u_head.key = tag_r;
    h_head     = '0;
    h_head.go  = h_go;
    h_head.req = size_r;
    h_head.s   = s_r;
    h_head.e   = e_r;
  end

  assign utok[0] = u_head;
  assign htok[0] = h_head;

  for (genvar i = 0; i < bfa_pkg::MAX_BLOCKS; i++) begin : g_used
    bfa_used_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (bfa_pkg::UIW'(i)),
      .clr      (u_clr),
      .wr_en    (u_wr_go && u_wr_idx == bfa_pkg::UIW'(i)),
      .wr       (u_wr),
      .done_clr (done_clr),
      .done_set (done_go && done_idx == bfa_pkg::UIW'(i)),
      .tok_in   (utok[i]),
      .tok_out  (utok[i+1])
    );
  end

  for (genvar i = 0; i < bfa_pkg::NHOLES; i++) begin : g_hole
    bfa_hole_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_idx   (bfa_pkg::HIW'(i)),
      .boot_valid (i == 0),
      .boot_size  ((i == 0) ? bfa_pkg::TOTAL_RESET : '0),
      .clr        (h_clr),
      .wr_en      (h_wr_go && h_wr_idx == bfa_pkg::HIW'(i)),
      .wr         (h_wr),
      .tok_in     (htok[i]),
      .tok_out    (htok[i+1])
    );
  end

  assign ur       = utok[bfa_pkg::MAX_BLOCKS];
  assign hr       = htok[bfa_pkg::NHOLES];
  assign out_free = !out_v || rsp.ready;
  assign moved    = {1'b0, ur.sel_start} != cur;
  assign cur_add  = cur + {1'b0, ur.sel_size};

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_v;
  assign rsp.status      = out_w.status;
  assign rsp.tag_out     = out_w.tag_out;
  assign rsp.block_start = out_w.block_start;
  assign rsp.block_size  = out_w.block_size;
  assign rsp.new_start   = out_w.new_start;
  assign rsp.move_count  = out_w.move_count;
  assign rsp.last        = out_w.last;

  function automatic bfa_pkg::rsp_word_t mk(input logic [3:0] st, input logic [31:0] tg,
                                            input logic [31:0] bs, input logic [31:0] sz);
    bfa_pkg::rsp_word_t w;
    w             = '0;
    w.status      = st;
    w.tag_out     = tg;
    w.block_start = bs;
    w.block_size  = sz;
    w.last        = 1'b1;
    return w;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_v    <= 1'b0;
      total    <= bfa_pkg::TOTAL_RESET;
      u_arm    <= 1'b0;
      u_go     <= 1'b0;
      h_arm    <= 1'b0;
      h_go     <= 1'b0;
      u_clr    <= 1'b0;
      h_clr    <= 1'b0;
      u_wr_go  <= 1'b0;
      h_wr_go  <= 1'b0;
      done_clr <= 1'b0;
      done_go  <= 1'b0;
    end else begin
      u_arm    <= 1'b0;
      h_arm    <= 1'b0;
      u_go     <= u_arm;
      h_go     <= h_arm;
      u_clr    <= 1'b0;
      h_clr    <= 1'b0;
      u_wr_go  <= 1'b0;
      h_wr_go  <= 1'b0;
      done_clr <= 1'b0;
      done_go  <= 1'b0;
      if (rsp.ready) begin
        out_v <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            type_r <= req.req_type;
            tag_r  <= req.block_tag;
            size_r <= req.req_size;
            u_arm  <= 1'b1;
            if (req.req_type == bfa_pkg::REQ_COMPACT) begin
              done_clr <= 1'b1;
              phase    <= 1'b0;
              cur      <= '0;
              moves    <= '0;
              k        <= '0;
            end
            state <= S_UPASS;
          end
        end

        S_UPASS: begin
          if (ur.go) begin
            unique case (type_r)
              bfa_pkg::REQ_ALLOC: begin
                if (ur.found) begin
                  res   <= mk(bfa_pkg::ST_DUP, tag_r, '0, '0);
                  state <= S_EMIT;
                end else if (!ur.has_slot) begin
                  res   <= mk(bfa_pkg::ST_FULL, tag_r, '0, '0);
                  state <= S_EMIT;
                end else begin
                  slot_r <= ur.sidx;
                  h_arm  <= 1'b1;
                  state  <= S_HPASS;
                end
              end
              bfa_pkg::REQ_FREE: begin
                if (!ur.found) begin
                  res   <= mk(bfa_pkg::ST_NOT_FOUND, tag_r, '0, '0);
                  state <= S_EMIT;
                end else begin
                  u_wr_go  <= 1'b1;
                  u_wr_idx <= ur.fidx;
                  u_wr     <= '0;
                  res      <= mk(bfa_pkg::ST_FREED, tag_r, ur.fstart, ur.fsize);
                  size_r   <= ur.fsize;
                  s_r      <= ur.fstart;
                  e_r      <= {1'b0, ur.fstart} + {1'b0, ur.fsize};
                  // an empty block returns no extent
                  if (ur.fsize == '0) begin
                    state <= S_EMIT;
                  end else begin
                    h_arm <= 1'b1;
                    state <= S_HPASS;
                  end
                end
              end
              bfa_pkg::REQ_QUERY: begin
                res   <= ur.found ? mk(bfa_pkg::ST_FOUND, tag_r, ur.fstart, ur.fsize)
                                  : mk(bfa_pkg::ST_QMISS, tag_r, '0, '0);
                state <= S_EMIT;
              end
              bfa_pkg::REQ_COMPACT: begin
                if (ur.sel) begin
                  done_go  <= 1'b1;
                  done_idx <= ur.sel_idx;
                  if (!phase || !moved) begin
                    if (moved) begin
                      moves <= moves + 1'b1;
                    end
                    cur   <= cur_add;
                    u_arm <= 1'b1;
                  end else begin
                    mv_idx   <= ur.sel_idx;
                    mv_tag   <= ur.sel_tag;
                    mv_start <= ur.sel_start;
                    mv_size  <= ur.sel_size;
                    state    <= S_CMOVE;
                  end
                end else if (!phase) begin
                  res   <= '{bfa_pkg::ST_COMPACTED, '0, '0, '0, '0, moves, moves == '0};
                  state <= S_CEMIT;
                end else begin
                  // at most one tail extent after packing
                  h_clr    <= 1'b1;
                  h_wr_go  <= 1'b1;
                  h_wr_idx <= '0;
                  h_wr     <= '{cur < {1'b0, total}, cur[bfa_pkg::AW-1:0],
                                total - cur[bfa_pkg::AW-1:0]};
                  state    <= S_IDLE;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end

        S_HPASS: begin
          if (hr.go) begin
            if (type_r == bfa_pkg::REQ_ALLOC) begin
              if (!hr.fit) begin
                res <= mk(bfa_pkg::ST_NO_SPACE, tag_r, '0, '0);
              end else begin
                u_wr_go  <= 1'b1;
                u_wr_idx <= slot_r;
                u_wr     <= '{1'b1, tag_r, hr.fit_start, size_r};
                h_wr_go  <= 1'b1;
                h_wr_idx <= hr.fit_idx;
                if (hr.fit_size == size_r) begin
                  h_wr <= '0;
                end else begin
                  h_wr <= '{1'b1, hr.fit_start + size_r, hr.fit_size - size_r};
                end
                res <= mk(bfa_pkg::ST_ALLOCATED, tag_r, hr.fit_start, size_r);
              end
              state <= S_EMIT;
            end else begin
              state <= S_EMIT;
              priority if (hr.prev && hr.nxt) begin
                h_wr_go  <= 1'b1;
                h_wr_idx <= hr.prev_idx;
                h_wr     <= '{1'b1, hr.prev_start, hr.prev_size + size_r + hr.nxt_size};
                nxt_r    <= hr.nxt_idx;
                state    <= S_UPD2;
              end else if (hr.prev) begin
                h_wr_go  <= 1'b1;
                h_wr_idx <= hr.prev_idx;
                h_wr     <= '{1'b1, hr.prev_start, hr.prev_size + size_r};
              end else if (hr.nxt) begin
                h_wr_go  <= 1'b1;
                h_wr_idx <= hr.nxt_idx;
                h_wr     <= '{1'b1, s_r, hr.nxt_size + size_r};
              end else if (hr.slot) begin
                h_wr_go  <= 1'b1;
                h_wr_idx <= hr.slot_idx;
                h_wr     <= '{1'b1, s_r, size_r};
              end else begin
                // no empty entry: extent dropped
                h_wr_go <= 1'b0;
              end
            end
          end
        end

        S_UPD2: begin
          h_wr_go  <= 1'b1;
          h_wr_idx <= nxt_r;
          h_wr     <= '0;
          state    <= S_EMIT;
        end

        S_EMIT: begin
          if (out_free) begin
            out_w <= res;
            out_v <= 1'b1;
            state <= S_IDLE;
          end
        end

        S_CEMIT: begin
          if (out_free) begin
            out_w <= res;
            out_v <= 1'b1;
            if (moves == '0) begin
              h_clr    <= 1'b1;
              h_wr_go  <= 1'b1;
              h_wr_idx <= '0;
              h_wr     <= '{cur < {1'b0, total}, cur[bfa_pkg::AW-1:0],
                            total - cur[bfa_pkg::AW-1:0]};
              state    <= S_IDLE;
            end else begin
              phase    <= 1'b1;
              cur      <= '0;
              done_clr <= 1'b1;
              u_arm    <= 1'b1;
              state    <= S_UPASS;
            end
          end
        end

        S_CMOVE: begin
          if (out_free) begin
            out_w    <= '{bfa_pkg::ST_MOVED, mv_tag, mv_start, '0, cur[bfa_pkg::AW-1:0],
                          '0, (k + 1'b1 == moves)};
            out_v    <= 1'b1;
            k        <= k + 1'b1;
            u_wr_go  <= 1'b1;
            u_wr_idx <= mv_idx;
            u_wr     <= '{1'b1, mv_tag, cur[bfa_pkg::AW-1:0], mv_size};
            cur      <= cur + {1'b0, mv_size};
            u_arm    <= 1'b1;
            state    <= S_UPASS;
          end
        end

        default: state <= S_IDLE;
      endcase

      if (cfg_we) begin
        total    <= cfg_wdata;
        u_clr    <= 1'b1;
        h_clr    <= 1'b1;
        h_wr_go  <= 1'b1;
        h_wr_idx <= '0;
        h_wr     <= '{cfg_wdata != '0, '0, cfg_wdata};
      end
    end
  end

endmodule

/* rtl/core/bfa_checker.sv */
// ----------------------------------------------------------------------------
// bfa_checker: port-level checks of the allocator
// Watches the response channel; bound to the top level.
// ----------------------------------------------------------------------------
module bfa_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [3:0]  status,
  input logic [31:0] block_start,
  input logic [31:0] new_start,
  input logic [4:0]  move_count,
  input logic        last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(block_start))
    else $error("rsp word changed while stalled");

  a_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != bfa_pkg::ST_COMPACTED && status != bfa_pkg::ST_MOVED |-> last)
    else $error("single-word result without last");

  // a zero-size block sharing a start can be pushed up, so only a change is checked
  a_move: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == bfa_pkg::ST_MOVED |-> new_start != block_start && move_count == 0)
    else $error("move record does not move");

  a_nomove: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == bfa_pkg::ST_COMPACTED |-> last == (move_count == 0))
    else $error("compacted last flag wrong");

  a_rst: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("rsp valid after reset");

endmodule

bind best_fit_allocator_core bfa_checker u_bfa_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .block_start (rsp.block_start),
  .new_start   (rsp.new_start),
  .move_count  (rsp.move_count),
  .last        (rsp.last)
);

/* sim/bfa_tb_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_tb_if: note file for the allocator channels
// The channel interfaces come from the RTL; this file only carries the
// request word type the bench shares between its processes.
// ----------------------------------------------------------------------------
package bfa_tb_pkg;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] tag;
    logic [31:0] size;
  } alloc_req_t;
endpackage

/* sim/tb_best_fit_allocator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_best_fit_allocator_core: self-checking bench of the best-fit allocator
// Drives alloc/free/query/compact words, predicts every result word from a
// behavioral copy of both tables, and compares field by field in order.
// ----------------------------------------------------------------------------
module tb_best_fit_allocator_core;

  localparam int LIMIT_CYCLES = 1500000;
  localparam int HOLD_LEN     = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  bfa_req_if req ();
  bfa_rsp_if rsp ();

  best_fit_allocator_core u_dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Behavioral copy of the allocator state
  // --------------------------------------------------------------------------
  logic [31:0] mem_total;
  logic        blk_valid [bfa_pkg::MAX_BLOCKS];
  logic [31:0] blk_tag   [bfa_pkg::MAX_BLOCKS];
  logic [31:0] blk_start [bfa_pkg::MAX_BLOCKS];
  logic [31:0] blk_size  [bfa_pkg::MAX_BLOCKS];
  logic        ext_valid [bfa_pkg::NHOLES];
  logic [31:0] ext_start [bfa_pkg::NHOLES];
  logic [31:0] ext_size  [bfa_pkg::NHOLES];

  bfa_pkg::rsp_word_t result_fifo[$];
  int        fail_cnt = 0;
  int        idle_pct = 0;     // sender idle chance
  int        stall_pct = 0;    // receiver stall chance
  logic      hold_go = 1'b0;   // request for one long receiver hold-off
  logic      hold_seen = 1'b0;
  int        hold_cnt = 0;     // hold-off cycles left, counted below

  function automatic bfa_pkg::rsp_word_t mk_word(logic [3:0] st, logic [31:0] tg,
                                                 logic [31:0] bs, logic [31:0] sz,
                                                 logic [31:0] ns, logic [4:0] mc,
                                                 logic lst);
    bfa_pkg::rsp_word_t w;
    w.status = st; w.tag_out = tg; w.block_start = bs; w.block_size = sz;
    w.new_start = ns; w.move_count = mc; w.last = lst;
    return w;
  endfunction

  function automatic void clear_tables(logic [31:0] total);
    mem_total = total;
    for (int i = 0; i < bfa_pkg::MAX_BLOCKS; i++) begin
      blk_valid[i] = 1'b0; blk_tag[i] = '0; blk_start[i] = '0; blk_size[i] = '0;
    end
    for (int i = 0; i < bfa_pkg::NHOLES; i++) begin
      ext_valid[i] = 1'b0; ext_start[i] = '0; ext_size[i] = '0;
    end
    ext_size[0]  = total;
    ext_valid[0] = (total != 0);
  endfunction

  function automatic int lookup_tag(logic [31:0] tg);
    for (int i = 0; i < bfa_pkg::MAX_BLOCKS; i++)
      if (blk_valid[i] && blk_tag[i] == tg) return i;
    return -1;
  endfunction

  // Return an extent, merging with neighbors; end addresses are summed 33 bits wide
  function automatic void give_back(logic [31:0] s, logic [31:0] sz);
    int prv, nxt;
    logic [32:0] e;
    prv = -1; nxt = -1;
    if (sz == 0) return;
    for (int i = 0; i < bfa_pkg::NHOLES; i++) begin
      if (!ext_valid[i]) continue;
      e = {1'b0, ext_start[i]} + ext_size[i];
      if (e == {1'b0, s}) prv = i;
      if ({1'b0, ext_start[i]} == {1'b0, s} + sz) nxt = i;
    end
    if (prv >= 0 && nxt >= 0) begin
      ext_size[prv] += sz + ext_size[nxt];
      ext_valid[nxt] = 1'b0;
    end else if (prv >= 0) begin
      ext_size[prv] += sz;
    end else if (nxt >= 0) begin
      ext_start[nxt] = s;
      ext_size[nxt] += sz;
    end else begin
      for (int i = 0; i < bfa_pkg::NHOLES; i++)
        if (!ext_valid[i]) begin
          ext_valid[i] = 1'b1; ext_start[i] = s; ext_size[i] = sz;
          return;
        end
    end
  endfunction

  // Predict all result words of one request and queue them
  function automatic void predict_request(bfa_tb_pkg::alloc_req_t r);
    int b, slot, fit, n, moves;
    int order[bfa_pkg::MAX_BLOCKS];
    logic [32:0] cur;
    bfa_pkg::rsp_word_t moved[$];
    case (r.kind)
      bfa_pkg::REQ_ALLOC: begin
        slot = -1; fit = -1;
        if (lookup_tag(r.tag) >= 0) begin
          result_fifo.push_back(mk_word(bfa_pkg::ST_DUP, r.tag, 0, 0, 0, 0, 1'b1));
          return;
        end
        for (int i = 0; i < bfa_pkg::MAX_BLOCKS; i++)
          if (!blk_valid[i]) begin slot = i; break; end
        if (slot < 0) begin
          result_fifo.push_back(mk_word(bfa_pkg::ST_FULL, r.tag, 0, 0, 0, 0, 1'b1));
          return;
        end
        for (int i = 0; i < bfa_pkg::NHOLES; i++) begin
          if (!ext_valid[i] || ext_size[i] < r.size) continue;
          if (fit < 0 || ext_size[i] < ext_size[fit] ||
              (ext_size[i] == ext_size[fit] && ext_start[i] < ext_start[fit])) fit = i;
        end
        if (fit < 0) begin
          result_fifo.push_back(mk_word(bfa_pkg::ST_NO_SPACE, r.tag, 0, 0, 0, 0, 1'b1));
          return;
        end
        blk_valid[slot] = 1'b1; blk_tag[slot] = r.tag;
        blk_start[slot] = ext_start[fit]; blk_size[slot] = r.size;
        if (ext_size[fit] == r.size) ext_valid[fit] = 1'b0;
        else begin
          ext_start[fit] += r.size;
          ext_size[fit]  -= r.size;
        end
        result_fifo.push_back(mk_word(bfa_pkg::ST_ALLOCATED, r.tag, blk_start[slot], r.size,
                                      0, 0, 1'b1));
      end
      bfa_pkg::REQ_COMPACT: begin
        n = 0; moves = 0; cur = '0;
        // stable insertion sort by start address
        for (int i = 0; i < bfa_pkg::MAX_BLOCKS; i++) begin
          int j;
          if (!blk_valid[i]) continue;
          j = n;
          while (j > 0 && blk_start[order[j-1]] > blk_start[i]) begin
            order[j] = order[j-1];
            j--;
          end
          order[j] = i;
          n++;
        end
        for (int i = 0; i < n; i++) begin
          b = order[i];
          if ({1'b0, blk_start[b]} != cur) begin
            moves++;
            moved.push_back(mk_word(bfa_pkg::ST_MOVED, blk_tag[b], blk_start[b], 0,
                                    cur[31:0], 0, 1'b0));
            blk_start[b] = cur[31:0];
          end
          cur += blk_size[b];
        end
        for (int i = 0; i < bfa_pkg::NHOLES; i++) ext_valid[i] = 1'b0;
        if (cur < {1'b0, mem_total}) begin
          ext_valid[0] = 1'b1; ext_start[0] = cur[31:0];
          ext_size[0] = mem_total - cur[31:0];
        end
        result_fifo.push_back(mk_word(bfa_pkg::ST_COMPACTED, 0, 0, 0, 0, 5'(moves),
                                      moves == 0));
        if (moves > 0) moved[moves-1].last = 1'b1;
        foreach (moved[k]) result_fifo.push_back(moved[k]);
      end
      bfa_pkg::REQ_FREE: begin
        b = lookup_tag(r.tag);
        if (b < 0) result_fifo.push_back(mk_word(bfa_pkg::ST_NOT_FOUND, r.tag, 0, 0, 0, 0,
                                                 1'b1));
        else begin
          blk_valid[b] = 1'b0;
          give_back(blk_start[b], blk_size[b]);
          result_fifo.push_back(mk_word(bfa_pkg::ST_FREED, r.tag, blk_start[b], blk_size[b],
                                        0, 0, 1'b1));
        end
      end
      default: begin
        b = lookup_tag(r.tag);
        if (b < 0) result_fifo.push_back(mk_word(bfa_pkg::ST_QMISS, r.tag, 0, 0, 0, 0, 1'b1));
        else result_fifo.push_back(mk_word(bfa_pkg::ST_FOUND, r.tag, blk_start[b],
                                           blk_size[b], 0, 0, 1'b1));
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Drivers and checker
  // --------------------------------------------------------------------------

  // receiver: random stall, or one counted long hold-off
  always @(posedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else if (hold_go && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_cnt  <= HOLD_LEN;
      rsp.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      rsp.ready <= 1'b0;
      hold_cnt  <= hold_cnt - 1;
    end else rsp.ready <= ($urandom_range(99) >= stall_pct);
  end

  // compare every accepted word against the oldest prediction
  always @(posedge clk) begin
    bfa_pkg::rsp_word_t exp_w;
    if (!rst && rsp.valid && rsp.ready) begin
      if (result_fifo.size() == 0) begin
        $error("unexpected result word, status %0d", rsp.status);
        fail_cnt++;
      end else begin
        exp_w = result_fifo.pop_front();
        if (rsp.status !== exp_w.status) begin
          $error("status exp %0d got %0d", exp_w.status, rsp.status); fail_cnt++;
        end
        if (rsp.tag_out !== exp_w.tag_out) begin
          $error("tag_out exp %0h got %0h", exp_w.tag_out, rsp.tag_out); fail_cnt++;
        end
        if (rsp.block_start !== exp_w.block_start) begin
          $error("block_start exp %0h got %0h", exp_w.block_start, rsp.block_start);
          fail_cnt++;
        end
        if (rsp.block_size !== exp_w.block_size) begin
          $error("block_size exp %0h got %0h", exp_w.block_size, rsp.block_size);
          fail_cnt++;
        end
        if (rsp.new_start !== exp_w.new_start) begin
          $error("new_start exp %0h got %0h", exp_w.new_start, rsp.new_start); fail_cnt++;
        end
        if (rsp.move_count !== exp_w.move_count) begin
          $error("move_count exp %0d got %0d", exp_w.move_count, rsp.move_count);
          fail_cnt++;
        end
        if (rsp.last !== exp_w.last) begin
          $error("last exp %0d got %0d", exp_w.last, rsp.last); fail_cnt++;
        end
      end
    end
  end

  // watchdog
  int cyc = 0;
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // send one word; predict at acceptance. valid stays high after the
  // accepting edge and is dropped by the next idle stretch or by drain
  task automatic send_word(logic [1:0] kind, logic [31:0] tg, logic [31:0] sz);
    bfa_tb_pkg::alloc_req_t r;
    if ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    r.kind = kind; r.tag = tg; r.size = sz;
    req.valid <= 1'b1; req.req_type <= kind; req.block_tag <= tg; req.req_size <= sz;
    do @(posedge clk); while (!req.ready);
    predict_request(r);
  endtask

  // idle point: all results in, then allow the block to settle
  task automatic drain();
    req.valid <= 1'b0;
    while (result_fifo.size() != 0) @(posedge clk);
    repeat (800) @(posedge clk);
  endtask

  task automatic write_total(logic [31:0] total);
    drain();
    cfg_we <= 1'b1; cfg_wdata <= total;
    @(posedge clk);
    cfg_we <= 1'b0;
    clear_tables(total);
  endtask

  // random request biased to a small tag pool so hits are common
  task automatic random_word(int span);
    logic [1:0] k;
    logic [31:0] tg, sz;
    k = $urandom_range(99) < 45 ? bfa_pkg::REQ_ALLOC : 2'($urandom_range(3));
    if ($urandom_range(99) < 6) k = bfa_pkg::REQ_COMPACT;
    tg = $urandom_range(99) < 90 ? 32'($urandom_range(24)) : $urandom;
    case ($urandom_range(9))
      0: sz = $urandom;
      1: sz = 0;
      default: sz = 32'($urandom_range(span));
    endcase
    send_word(k, tg, sz);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    // reset space of 65536: best fit, duplicate, miss cases
    send_word(bfa_pkg::REQ_ALLOC, 32'hFFFF_FFFF, 100);
    send_word(bfa_pkg::REQ_ALLOC, 32'hFFFF_FFFF, 5);          // duplicate tag
    send_word(bfa_pkg::REQ_ALLOC, 1, 300);
    send_word(bfa_pkg::REQ_ALLOC, 2, 50);
    send_word(bfa_pkg::REQ_ALLOC, 3, 32'hFFFF_FFFF);          // no space
    send_word(bfa_pkg::REQ_FREE, 32'hFFFF_FFFF, 0);           // hole at 0
    send_word(bfa_pkg::REQ_ALLOC, 4, 0);                      // zero-size takes best fit
    send_word(bfa_pkg::REQ_QUERY, 4, 0);
    send_word(bfa_pkg::REQ_QUERY, 77, 0);                     // query miss
    send_word(bfa_pkg::REQ_FREE, 77, 0);                      // free miss
    send_word(bfa_pkg::REQ_FREE, 4, 0);                       // zero-size free
    send_word(bfa_pkg::REQ_FREE, 2, 0);                       // merge with tail
    send_word(bfa_pkg::REQ_COMPACT, 0, 0);                    // one move
    send_word(bfa_pkg::REQ_COMPACT, 0, 0);                    // nothing moves
    for (int i = 0; i < 16; i++) send_word(bfa_pkg::REQ_ALLOC, 100 + i, 10);
    send_word(bfa_pkg::REQ_ALLOC, 200, 1);                    // table full
    write_total(0);
    send_word(bfa_pkg::REQ_ALLOC, 5, 0);                      // zero space: no extent
    write_total(32'hFFFF_FFFF);
    send_word(bfa_pkg::REQ_ALLOC, 0, 32'hFFFF_FFFF);          // fills whole space exactly
    send_word(bfa_pkg::REQ_COMPACT, 0, 0);                    // space full, no extent left
    send_word(bfa_pkg::REQ_FREE, 0, 0);
  endtask

  task automatic test_random(int count, int span);
    repeat (count) random_word(span);
  endtask

  task automatic test_backpressure();
    // long receiver hold-off while the sender keeps offering
    hold_go <= 1'b1;
    repeat (12) random_word(400);
    drain();                                         // sender pauses for all results
  endtask

  initial begin
    req.valid <= 1'b0; req.req_type <= bfa_pkg::REQ_QUERY;
    req.block_tag <= '0; req.req_size <= '0;
    clear_tables(bfa_pkg::TOTAL_RESET);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    write_total(4096);
    idle_pct = 0;  stall_pct = 0;  test_random(35, 600);
    write_total(1000);
    idle_pct = 77; stall_pct = 0;  test_random(30, 150);
    test_backpressure();
    write_total(32'hFFFF_FFFF);
    idle_pct = 0;  stall_pct = 77; test_random(33, 32'h7FFF_FFFF);
    write_total(256);
    idle_pct = 6;  stall_pct = 6;  test_random(35, 40);
    idle_pct = 0;  stall_pct = 0;
    drain();
    if (fail_cnt == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* files.f */
rtl/core/bfa_pkg.sv
rtl/core/bfa_if.sv
rtl/core/bfa_used_cell.sv
rtl/core/bfa_hole_cell.sv
rtl/core/best_fit_allocator_core.sv
rtl/core/bfa_checker.sv
sim/bfa_tb_if.sv
sim/tb_best_fit_allocator_core.sv
